// File: design/acm_pkg.sv
// Package for the multi-pattern match counter.
// Holds the opcodes, sequencer states and fixed field widths; no dependencies.
package acm_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_BUILD  = 2'd1,
		OP_SCAN   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		S_CLR,
		S_IDLE,
		S_INS_RD,
		S_INS_CHK,
		S_INS_END,
		S_INS_CNT,
		S_BLD_CRD,
		S_BLD_CCHK,
		S_BLD_FRD,
		S_BLD_FCHK,
		S_BLD_FNX,
		S_BLD_VRD,
		S_BLD_VWR,
		S_BLD_NEXT,
		S_BLD_POP,
		S_BLD_UFAIL,
		S_SC_RD,
		S_SC_CHK,
		S_SC_FNX,
		S_SC_WRD,
		S_SC_WCHK,
		S_SC_END,
		S_OUT
	} state_t;

	localparam int COUNT_W   = 13;
	localparam int TOTAL_W   = 16;
	localparam int SYM_W     = 5;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

endpackage

// File: design/acm_ram.sv
// Single-port-write, single-port-read memory with registered read data.
// Used for the child links, node records and breadth-first queue; no dependencies.
module acm_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/multi_pattern_match_counter.sv
// Multi-pattern match counter: trie insert, failure-link build, text scan, clear.
// Insert sweeps the ALPHABET child slots of each new node; clear sweeps the root's slots.
// Scan follows failure links on a miss, then counts fail-chain nodes not yet counted.
// Build visits the trie breadth-first through the queue and sets each child's failure link.
// One request at a time; an untaken result holds the input. Depends on acm_pkg, acm_ram.
// Reset: sweeps the root's ALPHABET child slots before the first request is taken.
module multi_pattern_match_counter #(
	parameter int MAX_NODES = 8192,
	parameter int ALPHABET  = 26
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [4:0] symbol
	input  logic [1:0]  s_tuser,  // [1:0] opcode
	input  logic        s_tlast,  // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [15:0] match_count, [16] status
	output logic [1:0]  m_tuser   // [1:0] op_done
);

	localparam int NW  = $clog2(MAX_NODES);
	localparam int SW  = $clog2(ALPHABET);
	localparam int CD  = MAX_NODES * ALPHABET;
	localparam int CAW = $clog2(CD);
	localparam int CWW = NW + 1;
	localparam int NDW = NW + acm_pkg::COUNT_W + 1;
	localparam logic [NW-1:0] ROOT = '0;

	function automatic logic [CAW-1:0] slot(input logic [NW-1:0] n, input logic [CAW-1:0] s);
		logic [CAW-1:0] base;
		base = CAW'(n) * CAW'(ALPHABET);
		return base + s;
	endfunction

	acm_pkg::state_t state_q, state_d;
	acm_pkg::op_t    op_q, op_d;
	logic [acm_pkg::SYM_W-1:0] sym_q, sym_d;
	logic last_q, last_d, trunc_q, trunc_d, root_q, root_d;
	logic [NW-1:0] cur_q, cur_d, scan_q, scan_d, f_q, f_d, u_q, u_d, v_q, v_d;
	logic [NW-1:0] nf_q, nf_d, failu_q, failu_d, clrn_q, clrn_d;
	logic [NW:0] used_q, used_d, head_q, head_d, tail_q, tail_d;
	logic [SW-1:0] c_q, c_d;
	logic [acm_pkg::TOTAL_W-1:0] total_q, total_d, rcnt_q, rcnt_d;
	logic rst_q, rst_d;
	logic m_tvalid_q, m_tvalid_d;
	logic [23:0] m_tdata_q, m_tdata_d;
	logic [1:0] m_tuser_q, m_tuser_d;

	logic c_we, n_we, q_we;
	logic [CAW-1:0] c_wa, c_ra;
	logic [CWW-1:0] c_wd, c_rd;
	logic [NW-1:0] n_wa, n_ra, q_wa, q_ra, q_wd, q_rd;
	logic [NDW-1:0] n_wd, n_rd;

	logic c_vld, nd_cons, sym_ok;
	logic [NW-1:0] c_lnk, nd_fail;
	logic [acm_pkg::COUNT_W-1:0] nd_cnt;
	logic [acm_pkg::TOTAL_W:0] sum;

	acm_ram #(.W(CWW), .D(CD)) u_child (
		.clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd)
	);
	acm_ram #(.W(NDW), .D(MAX_NODES)) u_node (
		.clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd)
	);
	acm_ram #(.W(NW), .D(MAX_NODES)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd)
	);

	assign c_vld   = c_rd[NW];
	assign c_lnk   = c_rd[NW-1:0];
	assign nd_fail = n_rd[NW-1:0];
	assign nd_cnt  = n_rd[NW+acm_pkg::COUNT_W-1:NW];
	assign nd_cons = n_rd[NDW-1];
	assign sum     = {1'b0, total_q} + (acm_pkg::TOTAL_W+1)'(nd_cnt);

	assign s_tready = (state_q == acm_pkg::S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= acm_pkg::S_CLR;
			op_q       <= acm_pkg::OP_INSERT;
			last_q     <= 1'b0;
			trunc_q    <= 1'b0;
			root_q     <= 1'b0;
			cur_q      <= '0;
			scan_q     <= '0;
			clrn_q     <= '0;
			used_q     <= (NW+1)'(1);
			head_q     <= '0;
			tail_q     <= '0;
			c_q        <= '0;
			total_q    <= '0;
			rst_q      <= 1'b1;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			op_q       <= op_d;
			last_q     <= last_d;
			trunc_q    <= trunc_d;
			root_q     <= root_d;
			cur_q      <= cur_d;
			scan_q     <= scan_d;
			clrn_q     <= clrn_d;
			used_q     <= used_d;
			head_q     <= head_d;
			tail_q     <= tail_d;
			c_q        <= c_d;
			total_q    <= total_d;
			rst_q      <= rst_d;
			m_tvalid_q <= m_tvalid_d;
		end
	end

	always_ff @(posedge clk) begin
		sym_q     <= sym_d;
		f_q       <= f_d;
		u_q       <= u_d;
		v_q       <= v_d;
		nf_q      <= nf_d;
		failu_q   <= failu_d;
		rcnt_q    <= rcnt_d;
		m_tdata_q <= m_tdata_d;
		m_tuser_q <= m_tuser_d;
	end

	always_comb begin
		state_d = state_q; op_d = op_q; sym_d = sym_q; last_d = last_q;
		trunc_d = trunc_q; root_d = root_q; cur_d = cur_q; scan_d = scan_q;
		f_d = f_q; u_d = u_q; v_d = v_q; nf_d = nf_q; failu_d = failu_q;
		clrn_d = clrn_q; used_d = used_q; head_d = head_q; tail_d = tail_q;
		c_d = c_q; total_d = total_q; rcnt_d = rcnt_q; rst_d = rst_q;
		m_tvalid_d = m_tvalid_q; m_tdata_d = m_tdata_q; m_tuser_d = m_tuser_q;
		c_we = 1'b0; c_wa = slot(cur_q, CAW'(sym_q)); c_wd = '0;
		c_ra = slot(f_q, CAW'(sym_q));
		n_we = 1'b0; n_wa = v_q; n_wd = n_rd; n_ra = f_q;
		q_we = 1'b0; q_wa = tail_q[NW-1:0]; q_wd = v_q; q_ra = head_q[NW-1:0];
		sym_ok = ({3'b0, sym_q} < 8'(ALPHABET));

		if (m_tvalid_q && m_tready) begin
			m_tvalid_d = 1'b0;
		end

		unique case (state_q)
			acm_pkg::S_CLR: begin
				c_we = 1'b1;
				c_wa = slot(clrn_q, CAW'(c_q));
				c_wd = '0;
				if (c_q == '0) begin
					n_we = 1'b1;
					n_wa = clrn_q;
					n_wd = {1'b0, {acm_pkg::COUNT_W{1'b0}}, ROOT};
				end
				if (c_q == SW'(ALPHABET - 1)) begin
					c_d = '0;
					rst_d = 1'b0;
					if (op_q == acm_pkg::OP_CLEAR && !rst_q) begin
						rcnt_d = '0;
						state_d = acm_pkg::S_OUT;
					end else if (rst_q) begin
						state_d = acm_pkg::S_IDLE;
					end else begin
						state_d = acm_pkg::S_INS_END;
					end
				end else begin
					c_d = c_q + SW'(1);
				end
			end
			acm_pkg::S_IDLE: begin
				if (s_tvalid) begin
					op_d = acm_pkg::op_t'(s_tuser);
					sym_d = s_tdata[acm_pkg::SYM_W-1:0];
					last_d = s_tlast;
					sym_ok = ({3'b0, s_tdata[acm_pkg::SYM_W-1:0]} < 8'(ALPHABET));
					unique case (acm_pkg::op_t'(s_tuser))
						acm_pkg::OP_INSERT: begin
							state_d = (trunc_q || !sym_ok) ? acm_pkg::S_INS_END
								: acm_pkg::S_INS_RD;
						end
						acm_pkg::OP_BUILD: begin
							u_d = ROOT; root_d = 1'b1; c_d = '0;
							head_d = '0; tail_d = '0;
							state_d = acm_pkg::S_BLD_CRD;
						end
						acm_pkg::OP_SCAN: begin
							if (!sym_ok) begin
								scan_d = ROOT;
								state_d = acm_pkg::S_SC_END;
							end else begin
								f_d = scan_q;
								state_d = acm_pkg::S_SC_RD;
							end
						end
						default: begin
							used_d = (NW+1)'(1); cur_d = ROOT; scan_d = ROOT;
							total_d = '0; trunc_d = 1'b0; clrn_d = ROOT; c_d = '0;
							state_d = acm_pkg::S_CLR;
						end
					endcase
				end
			end
			acm_pkg::S_INS_RD: begin
				c_ra = slot(cur_q, CAW'(sym_q));
				state_d = acm_pkg::S_INS_CHK;
			end
			acm_pkg::S_INS_CHK: begin
				if (c_vld) begin
					cur_d = c_lnk;
					state_d = acm_pkg::S_INS_END;
				end else if (used_q < (NW+1)'(MAX_NODES)) begin
					c_we = 1'b1;
					c_wd = {1'b1, used_q[NW-1:0]};
					cur_d = used_q[NW-1:0];
					clrn_d = used_q[NW-1:0];
					used_d = used_q + (NW+1)'(1);
					c_d = '0;
					state_d = acm_pkg::S_CLR;
				end else begin
					trunc_d = 1'b1;
					state_d = acm_pkg::S_INS_END;
				end
			end
			acm_pkg::S_INS_END: begin
				n_ra = cur_q;
				if (!last_q) begin
					state_d = acm_pkg::S_IDLE;
				end else if (!trunc_q && cur_q != ROOT) begin
					state_d = acm_pkg::S_INS_CNT;
				end else begin
					rcnt_d = '0;
					state_d = acm_pkg::S_OUT;
				end
			end
			acm_pkg::S_INS_CNT: begin
				if (nd_cnt != acm_pkg::COUNT_MAX) begin
					n_we = 1'b1;
					n_wa = cur_q;
					n_wd = {nd_cons, nd_cnt + acm_pkg::COUNT_W'(1), nd_fail};
				end
				rcnt_d = '0;
				state_d = acm_pkg::S_OUT;
			end
			acm_pkg::S_BLD_CRD: begin
				c_ra = slot(u_q, CAW'(c_q));
				state_d = acm_pkg::S_BLD_CCHK;
			end
			acm_pkg::S_BLD_CCHK: begin
				if (!c_vld) begin
					state_d = acm_pkg::S_BLD_NEXT;
				end else begin
					v_d = c_lnk;
					if (root_q) begin
						nf_d = ROOT;
						state_d = acm_pkg::S_BLD_VRD;
					end else begin
						f_d = failu_q;
						state_d = acm_pkg::S_BLD_FRD;
					end
				end
			end
			acm_pkg::S_BLD_FRD: begin
				c_ra = slot(f_q, CAW'(c_q));
				state_d = acm_pkg::S_BLD_FCHK;
			end
			acm_pkg::S_BLD_FCHK: begin
				n_ra = f_q;
				if (c_vld) begin
					nf_d = c_lnk;
					state_d = acm_pkg::S_BLD_VRD;
				end else if (f_q == ROOT) begin
					nf_d = ROOT;
					state_d = acm_pkg::S_BLD_VRD;
				end else begin
					state_d = acm_pkg::S_BLD_FNX;
				end
			end
			acm_pkg::S_BLD_FNX: begin
				f_d = nd_fail;
				state_d = acm_pkg::S_BLD_FRD;
			end
			acm_pkg::S_BLD_VRD: begin
				n_ra = v_q;
				state_d = acm_pkg::S_BLD_VWR;
			end
			acm_pkg::S_BLD_VWR: begin
				n_we = 1'b1;
				n_wa = v_q;
				n_wd = {nd_cons, nd_cnt, nf_q};
				if (tail_q < (NW+1)'(MAX_NODES)) begin
					q_we = 1'b1;
					tail_d = tail_q + (NW+1)'(1);
				end
				state_d = acm_pkg::S_BLD_NEXT;
			end
			acm_pkg::S_BLD_NEXT: begin
				if (c_q == SW'(ALPHABET - 1)) begin
					if (head_q < tail_q) begin
						head_d = head_q + (NW+1)'(1);
						state_d = acm_pkg::S_BLD_POP;
					end else begin
						rcnt_d = '0;
						state_d = acm_pkg::S_OUT;
					end
				end else begin
					c_d = c_q + SW'(1);
					state_d = acm_pkg::S_BLD_CRD;
				end
			end
			acm_pkg::S_BLD_POP: begin
				u_d = q_rd;
				n_ra = q_rd;
				state_d = acm_pkg::S_BLD_UFAIL;
			end
			acm_pkg::S_BLD_UFAIL: begin
				failu_d = nd_fail;
				root_d = 1'b0;
				c_d = '0;
				state_d = acm_pkg::S_BLD_CRD;
			end
			acm_pkg::S_SC_RD: begin
				c_ra = slot(f_q, CAW'(sym_q));
				state_d = acm_pkg::S_SC_CHK;
			end
			acm_pkg::S_SC_CHK: begin
				n_ra = f_q;
				if (c_vld) begin
					f_d = c_lnk;
					scan_d = c_lnk;
					state_d = acm_pkg::S_SC_WRD;
				end else if (f_q == ROOT) begin
					scan_d = ROOT;
					state_d = acm_pkg::S_SC_END;
				end else begin
					state_d = acm_pkg::S_SC_FNX;
				end
			end
			acm_pkg::S_SC_FNX: begin
				f_d = nd_fail;
				state_d = acm_pkg::S_SC_RD;
			end
			acm_pkg::S_SC_WRD: begin
				n_ra = f_q;
				state_d = (f_q == ROOT) ? acm_pkg::S_SC_END : acm_pkg::S_SC_WCHK;
			end
			acm_pkg::S_SC_WCHK: begin
				if (nd_cons) begin
					state_d = acm_pkg::S_SC_END;
				end else begin
					total_d = sum[acm_pkg::TOTAL_W] ? acm_pkg::TOTAL_MAX
						: sum[acm_pkg::TOTAL_W-1:0];
					n_we = 1'b1;
					n_wa = f_q;
					n_wd = {1'b1, nd_cnt, nd_fail};
					f_d = nd_fail;
					state_d = acm_pkg::S_SC_WRD;
				end
			end
			acm_pkg::S_SC_END: begin
				if (last_q) begin
					rcnt_d = total_q;
					total_d = '0;
					scan_d = ROOT;
					state_d = acm_pkg::S_OUT;
				end else begin
					state_d = acm_pkg::S_IDLE;
				end
			end
			acm_pkg::S_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					m_tvalid_d = 1'b1;
					m_tuser_d = op_q;
					m_tdata_d = {7'b0, (op_q == acm_pkg::OP_INSERT) ? trunc_q : 1'b0, rcnt_q};
					if (op_q == acm_pkg::OP_INSERT) begin
						cur_d = ROOT;
						trunc_d = 1'b0;
					end
					state_d = acm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = acm_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// File: sim/multi_pattern_match_counter_tb.sv
// Testbench for the multi-pattern match counter: trie insert, link build, text scan, clear.
// Holds its own automaton predictor and checks every result in order of request.
// Depends on acm_pkg and the multi_pattern_match_counter RTL.
module multi_pattern_match_counter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODES = 8192;
	localparam int ALPH  = 26;

	typedef struct {
		acm_pkg::op_t                op;
		logic [acm_pkg::TOTAL_W-1:0] count;
		logic                        status;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [1:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;

	multi_pattern_match_counter DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// automaton mirror
	bit                          kid_ok [NODES*ALPH];
	logic [12:0]                 kid    [NODES*ALPH];
	logic [12:0]                 fail   [NODES];
	logic [acm_pkg::COUNT_W-1:0] hits   [NODES];
	bit                          spent  [NODES];
	logic [12:0]                 bfs    [NODES];
	int                          node_cnt;
	int                          cursor;
	int                          scan_at;
	int                          total;
	bit                          cut;
	bit                          unbuilt;

	outcome_t results_due[$];
	int       mismatches;
	int       tx_idle;
	int       rx_idle;
	int       hold_reqs;
	int       hold_seen;
	int       hold_off;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("TB_ERROR");
		$finish;
	end

	function void fresh(int n);
		for (int c = 0; c < ALPH; c++) kid_ok[n*ALPH+c] = 0;
		hits[n] = '0;
		spent[n] = 0;
		fail[n] = '0;
	endfunction

	function void link_failures();
		int head, tail, u, v, f, idx;
		head = 0;
		tail = 0;
		fail[0] = '0;
		for (int c = 0; c < ALPH; c++) if (kid_ok[c]) begin
			fail[kid[c]] = '0;
			bfs[tail] = kid[c];
			tail++;
		end
		while (head < tail) begin
			u = bfs[head];
			head++;
			for (int c = 0; c < ALPH; c++) begin
				idx = u*ALPH + c;
				if (!kid_ok[idx]) continue;
				v = kid[idx];
				f = fail[u];
				while (f != 0 && !kid_ok[f*ALPH+c]) f = fail[f];
				fail[v] = kid_ok[f*ALPH+c] ? kid[f*ALPH+c] : 13'd0;
				bfs[tail] = 13'(v);
				tail++;
			end
		end
		unbuilt = 0;
	endfunction

	function void follow_text(int sym);
		int p, t;
		if (sym >= ALPH) begin
			scan_at = 0;
			return;
		end
		p = scan_at;
		while (p != 0 && !kid_ok[p*ALPH+sym]) p = fail[p];
		p = kid_ok[p*ALPH+sym] ? kid[p*ALPH+sym] : 0;
		scan_at = p;
		t = p;
		while (t != 0 && !spent[t]) begin
			total += hits[t];
			if (total > 65535) total = 65535;
			spent[t] = 1;
			t = fail[t];
		end
	endfunction

	function void grow_trie(int sym);
		int slot;
		if (cut || sym >= ALPH) return;
		slot = cursor*ALPH + sym;
		if (kid_ok[slot]) cursor = kid[slot];
		else if (node_cnt < NODES) begin
			fresh(node_cnt);
			kid[slot] = 13'(node_cnt);
			kid_ok[slot] = 1;
			cursor = node_cnt;
			node_cnt++;
			unbuilt = 1;
		end else cut = 1;
	endfunction

	function void predict_request(acm_pkg::op_t op, int sym, bit fin);
		outcome_t o;
		o.op = op;
		o.count = '0;
		o.status = 0;
		case (op)
			acm_pkg::OP_INSERT: begin
				grow_trie(sym);
				if (!fin) return;
				if (!cut && cursor != 0 && hits[cursor] != acm_pkg::COUNT_MAX) hits[cursor]++;
				o.status = cut;
				cursor = 0;
				cut = 0;
			end
			acm_pkg::OP_BUILD: link_failures();
			acm_pkg::OP_SCAN: begin
				follow_text(sym);
				if (!fin) return;
				o.count = total[15:0];
				total = 0;
				scan_at = 0;
			end
			default: begin
				node_cnt = 1;
				fresh(0);
				cursor = 0;
				scan_at = 0;
				total = 0;
				cut = 0;
				unbuilt = 0;
			end
		endcase
		results_due.push_back(o);
	endfunction

	task send_req(acm_pkg::op_t op, int sym, bit fin);
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {3'b000, sym[4:0]};
		s_tlast <= fin;
		do @(posedge clk); while (!s_tready);
		predict_request(op, sym, fin);
	endtask

	task send_word(acm_pkg::op_t op, string w);
		int sym;
		for (int i = 0; i < w.len(); i++) begin
			sym = (w[i] == "#") ? 31 : int'(w[i]) - 97;
			send_req(op, sym, i == w.len() - 1);
		end
	endtask

	task drain();
		s_tvalid <= 1'b0;
		wait (results_due.size() == 0);
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_off <= 0;
			hold_seen <= 0;
		end else if (hold_reqs != hold_seen) begin
			m_tready <= 1'b0;
			hold_off <= 400;
			hold_seen <= hold_reqs;
		end else if (hold_off > 0) begin
			m_tready <= 1'b0;
			hold_off <= hold_off - 1;
		end else m_tready <= ($urandom_range(99) >= rx_idle);
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (results_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result op %0d data %h", m_tuser, m_tdata);
			end else begin
				want = results_due.pop_front();
				if (m_tuser != want.op || m_tdata[15:0] != want.count
						|| m_tdata[16] != want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected op %0d count %0d status %0d, got op %0d count %0d status %0d",
							want.op, want.count, want.status, m_tuser, m_tdata[15:0], m_tdata[16]);
				end
			end
		end
	end

	task test_directed();
		send_req(acm_pkg::OP_CLEAR, 0, 0);
		send_word(acm_pkg::OP_INSERT, "he");
		send_word(acm_pkg::OP_INSERT, "she");
		send_word(acm_pkg::OP_INSERT, "his");
		send_word(acm_pkg::OP_INSERT, "hers");
		send_word(acm_pkg::OP_INSERT, "he");
		send_word(acm_pkg::OP_INSERT, "{#");
		send_word(acm_pkg::OP_INSERT, "q#z");
		send_req(acm_pkg::OP_BUILD, 0, 1);
		send_word(acm_pkg::OP_SCAN, "ushers");
		send_word(acm_pkg::OP_SCAN, "ushers");
		send_word(acm_pkg::OP_SCAN, "qzh#his");
		send_req(acm_pkg::OP_SCAN, 18, 0);
		send_req(acm_pkg::OP_BUILD, 0, 0);
		send_req(acm_pkg::OP_SCAN, 4, 1);
		send_req(acm_pkg::OP_CLEAR, 31, 1);
		send_word(acm_pkg::OP_SCAN, "he~");
		drain();
	endtask

	task test_repeat_counts();
		send_req(acm_pkg::OP_CLEAR, 0, 0);
		repeat (5) send_word(acm_pkg::OP_INSERT, "ab");
		repeat (3) send_word(acm_pkg::OP_INSERT, "b");
		send_word(acm_pkg::OP_INSERT, "bab");
		send_req(acm_pkg::OP_BUILD, 0, 1);
		send_word(acm_pkg::OP_SCAN, "abab");
		send_word(acm_pkg::OP_SCAN, "bab");
		send_req(acm_pkg::OP_CLEAR, 0, 0);
		drain();
	endtask

	function int pick_sym();
		return ($urandom_range(9) < 8) ? int'($urandom_range(3)) : int'($urandom_range(31));
	endfunction

	task test_random(int goal);
		int sent, len;
		acm_pkg::op_t op;
		sent = 0;
		while (sent < goal) begin
			if (node_cnt > 200 || $urandom_range(7) == 0) begin
				send_req(acm_pkg::OP_CLEAR, int'($urandom_range(31)), 1'($urandom_range(1)));
				sent++;
			end
			repeat ($urandom_range(1, 4)) begin
				len = $urandom_range(1, 5);
				for (int i = 0; i < len; i++)
					send_req(acm_pkg::OP_INSERT, pick_sym(), i == len - 1);
				sent += len;
			end
			send_req(acm_pkg::OP_BUILD, int'($urandom_range(31)), 1'($urandom_range(1)));
			sent++;
			repeat ($urandom_range(1, 4)) begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					send_req(acm_pkg::OP_SCAN, pick_sym(), i == len - 1);
				sent += len;
			end
			repeat ($urandom_range(0, 3)) begin
				op = acm_pkg::op_t'($urandom_range(3));
				if (op == acm_pkg::OP_SCAN && unbuilt) send_req(acm_pkg::OP_BUILD, 0, 0);
				send_req(op, int'($urandom_range(31)), 1'($urandom_range(1)));
				sent++;
			end
		end
		drain();
	endtask

	task test_backpressure();
		send_word(acm_pkg::OP_INSERT, "ab");
		send_req(acm_pkg::OP_BUILD, 0, 0);
		drain();
		hold_reqs++;
		repeat (20) send_req(acm_pkg::OP_SCAN, int'($urandom_range(1)), 1);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		hold_reqs = 0;
		mismatches = 0;
		tx_idle = 0;
		rx_idle = 0;
		node_cnt = 1;
		fresh(0);
		cursor = 0;
		scan_at = 0;
		total = 0;
		cut = 0;
		unbuilt = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle = 21;
		rx_idle = 62;
		test_directed();
		test_repeat_counts();
		test_random(150);
		test_backpressure();
		tx_idle = 62;
		rx_idle = 21;
		test_random(150);
		tx_idle = 0;
		rx_idle = 0;
		test_random(150);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && results_due.size() == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule

// File: multi_pattern_match_counter.f
design/acm_pkg.sv
design/acm_ram.sv
design/multi_pattern_match_counter.sv
sim/multi_pattern_match_counter_tb.sv
